// ===== hw/rtl/upscl_pkg.sv =====
// Shared types, constants and pixel arithmetic for the bilinear 2x upscaler.
`default_nettype none
package upscl_pkg;

	localparam int unsigned MAX_WIDTH  = 2048;
	localparam int unsigned MAX_HEIGHT = 4096;

	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
	localparam int unsigned OCOL_W = COL_W + 1;
	localparam int unsigned OROW_W = ROW_W + 1;

	localparam int unsigned FW_W   = 12;
	localparam int unsigned FH_W   = 13;
	localparam int unsigned CFG_W  = 13;
	localparam int unsigned CFG_AW = 2;

	localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [FW_W-1:0] RESET_WIDTH  = 12'd640;
	localparam logic [FH_W-1:0] RESET_HEIGHT = 13'd480;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [1:0] ROW_ABOVE = 2'd0;
	localparam logic [1:0] ROW_EVEN  = 2'd1;
	localparam logic [1:0] ROW_BELOW = 2'd2;

	localparam logic [1:0] COL_LEFT_EVEN = 2'd0;
	localparam logic [1:0] COL_LEFT_ODD  = 2'd1;
	localparam logic [1:0] COL_EDGE_EVEN = 2'd2;
	localparam logic [1:0] COL_EDGE_ODD  = 2'd3;

	typedef logic [23:0] pix_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [OCOL_W-1:0] out_col;
		logic [OROW_W-1:0] out_row;
		logic [7:0]        out_blue;
		logic [7:0]        out_green;
		logic [7:0]        out_red;
		logic              run_last;
	} out_item_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             has_left;
		logic             last_col;
		logic             has_above;
		logic             last_row;
		pix_t             up0;
		pix_t             up1;
		pix_t             up2;
		pix_t             mid0;
		pix_t             mid1;
		pix_t             mid2;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [7:0] half_even(input logic [7:0] a);
		logic [7:0] h;
		h = {1'b0, a[7:1]} + {7'd0, a[0] & a[1]};
		return h;
	endfunction

	function automatic pix_t mean_px(input pix_t p, input pix_t q);
		pix_t       res;
		logic [8:0] s;
		res = '0;
		for (int ch = 0; ch < 3; ch++) begin
			s = {1'b0, half_even(p[ch*8 +: 8])} + {1'b0, half_even(q[ch*8 +: 8])};
			res[ch*8 +: 8] = s[8] ? 8'hFF : s[7:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/upscl_front.sv =====
// Front end: configuration, frame counters, line buffer and mean computation per source pixel.
`default_nettype none
module upscl_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [upscl_pkg::CFG_AW-1:0]    cfg_addr,
	input  wire logic [upscl_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                            push,
	output logic                                 full,
	input  wire upscl_pkg::in_item_t             pixel,
	output logic                                 job_push,
	output upscl_pkg::job_t                      job,
	input  wire upscl_pkg::fifo_stat_t           fifo_stat
);

	logic [upscl_pkg::FW_W-1:0]  fw_q;
	logic [upscl_pkg::FH_W-1:0]  fh_q;
	logic [upscl_pkg::COL_W-1:0] col_q;
	logic [upscl_pkg::ROW_W-1:0] row_q;
	upscl_pkg::pix_t             left_q;
	upscl_pkg::pix_t             al_q;
	logic                        s1_vld_q;

	upscl_pkg::pix_t             cur_s1;
	upscl_pkg::pix_t             left_s1;
	upscl_pkg::pix_t             above_s1;
	logic [upscl_pkg::COL_W-1:0] col_s1;
	logic [upscl_pkg::ROW_W-1:0] row_s1;
	logic                        has_left_s1;
	logic                        last_col_s1;
	logic                        has_above_s1;
	logic                        last_row_s1;

	upscl_pkg::pix_t             line_mem [upscl_pkg::MAX_WIDTH];

	logic                        accept;
	logic                        cfg_hit;
	logic                        need_push_s1;
	logic                        s1_adv;
	logic                        last_col;
	logic                        last_row;
	logic [upscl_pkg::FW_W-1:0]  fw_m1;
	logic [upscl_pkg::FH_W-1:0]  fh_m1;
	logic [upscl_pkg::COL_W-1:0] wm1;
	logic [upscl_pkg::ROW_W-1:0] hm1;
	upscl_pkg::pix_t             cur_in;
	upscl_pkg::pix_t             a1;
	upscl_pkg::pix_t             e1;

	assign cur_in = {pixel.in_red, pixel.in_green, pixel.in_blue};

	assign fw_m1 = fw_q - 1'b1;
	assign fh_m1 = fh_q - 1'b1;

	always_comb begin
		if (fw_q == '0) begin
			wm1 = '0;
		end else if (fw_q > upscl_pkg::FW_W'(upscl_pkg::MAX_WIDTH)) begin
			wm1 = upscl_pkg::COL_W'(upscl_pkg::MAX_WIDTH - 1);
		end else begin
			wm1 = fw_m1[upscl_pkg::COL_W-1:0];
		end
		if (fh_q == '0) begin
			hm1 = '0;
		end else if (fh_q > upscl_pkg::FH_W'(upscl_pkg::MAX_HEIGHT)) begin
			hm1 = upscl_pkg::ROW_W'(upscl_pkg::MAX_HEIGHT - 1);
		end else begin
			hm1 = fh_m1[upscl_pkg::ROW_W-1:0];
		end
	end

	assign last_col = col_q >= wm1;
	assign last_row = row_q >= hm1;

	always_comb begin
		case (cfg_addr)
			upscl_pkg::REG_FRAME_WIDTH:  cfg_hit = 1'b1;
			upscl_pkg::REG_FRAME_HEIGHT: cfg_hit = 1'b1;
			default:                     cfg_hit = 1'b0;
		endcase
	end

	assign need_push_s1 = has_left_s1 | last_col_s1;
	assign s1_adv       = s1_vld_q & (~need_push_s1 | ~fifo_stat.full);
	assign full         = s1_vld_q & need_push_s1 & fifo_stat.full;
	assign job_push     = s1_vld_q & need_push_s1 & ~fifo_stat.full;
	assign accept       = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= upscl_pkg::RESET_WIDTH;
			fh_q     <= upscl_pkg::RESET_HEIGHT;
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			al_q     <= '0;
			s1_vld_q <= 1'b0;
		end else begin
			if (cfg_wen && cfg_hit) begin
				col_q  <= '0;
				row_q  <= '0;
				left_q <= '0;
				al_q   <= '0;
			end else begin
				if (accept) begin
					left_q <= cur_in;
					if (last_col) begin
						col_q <= '0;
						row_q <= last_row ? '0 : row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				if (s1_adv) begin
					al_q <= above_s1;
				end
			end
			if (cfg_wen) begin
				case (cfg_addr)
					upscl_pkg::REG_FRAME_WIDTH:  fw_q <= cfg_wdata[upscl_pkg::FW_W-1:0];
					upscl_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_wdata[upscl_pkg::FH_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				s1_vld_q <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1       <= cur_in;
			left_s1      <= left_q;
			col_s1       <= col_q;
			row_s1       <= row_q;
			has_left_s1  <= col_q != '0;
			last_col_s1  <= last_col;
			has_above_s1 <= row_q != '0;
			last_row_s1  <= last_row;
		end
	end

	// The read returns the row above; the same entry then takes the current pixel.
	always_ff @(posedge clk) begin
		if (accept) begin
			above_s1        <= line_mem[col_q];
			line_mem[col_q] <= cur_in;
		end
	end

	assign a1 = upscl_pkg::mean_px(al_q, above_s1);
	assign e1 = upscl_pkg::mean_px(left_s1, cur_s1);

	always_comb begin
		job.col       = col_s1;
		job.row       = row_s1;
		job.has_left  = has_left_s1;
		job.last_col  = last_col_s1;
		job.has_above = has_above_s1;
		job.last_row  = last_row_s1;
		job.up0       = upscl_pkg::mean_px(al_q, left_s1);
		job.up1       = upscl_pkg::mean_px(a1, e1);
		job.up2       = upscl_pkg::mean_px(above_s1, cur_s1);
		job.mid0      = left_s1;
		job.mid1      = e1;
		job.mid2      = cur_s1;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/upscl_fifo.sv =====
// Short job queue between the front end and the output sequencer.
`default_nettype none
module upscl_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire upscl_pkg::job_t       wr_job,
	input  wire logic                  pop,
	output upscl_pkg::job_t            head,
	output upscl_pkg::fifo_stat_t      stat
);

	upscl_pkg::job_t               mem_q [upscl_pkg::FIFO_DEPTH];
	logic [upscl_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [upscl_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [upscl_pkg::FIFO_AW:0]   cnt_q;
	logic                          wr;
	logic                          rd;

	assign stat.full  = cnt_q == (upscl_pkg::FIFO_AW+1)'(upscl_pkg::FIFO_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign wr         = push & ~stat.full;
	assign rd         = pop & ~stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (upscl_pkg::FIFO_AW+1)'(upscl_pkg::FIFO_DEPTH))
		else $error("Job queue count exceeds its depth.");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("Front end pushed a job into a full queue.");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("Job queue count did not follow a write.");

endmodule
`default_nettype wire

// ===== hw/rtl/upscl_back.sv =====
// Output sequencer: steps through the results of each job into the output register.
`default_nettype none
module upscl_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire upscl_pkg::job_t       job,
	input  wire upscl_pkg::fifo_stat_t fifo_stat,
	output logic                       job_pop,
	output logic                       empty,
	input  wire logic                  pop,
	output upscl_pkg::out_item_t       result
);

	logic [1:0]            rs_q;
	logic [1:0]            cs_q;
	logic                  started_q;
	logic                  out_vld_q;
	upscl_pkg::out_item_t  result_q;

	logic [1:0]            rs_start;
	logic [1:0]            rs_end;
	logic [1:0]            cs_start;
	logic [1:0]            cs_end;
	logic [1:0]            rs;
	logic [1:0]            cs;
	logic                  last;
	logic                  emit;
	upscl_pkg::pix_t       px;
	upscl_pkg::pix_t       p0;
	upscl_pkg::pix_t       p1;
	upscl_pkg::pix_t       p2;
	upscl_pkg::out_item_t  nxt;

	assign rs_start = job.has_above ? upscl_pkg::ROW_ABOVE : upscl_pkg::ROW_EVEN;
	assign rs_end   = job.last_row ? upscl_pkg::ROW_BELOW : upscl_pkg::ROW_EVEN;
	assign cs_start = job.has_left ? upscl_pkg::COL_LEFT_EVEN : upscl_pkg::COL_EDGE_EVEN;
	assign cs_end   = job.last_col ? upscl_pkg::COL_EDGE_ODD : upscl_pkg::COL_LEFT_ODD;

	assign rs   = started_q ? rs_q : rs_start;
	assign cs   = started_q ? cs_q : cs_start;
	assign last = (rs == rs_end) && (cs == cs_end);

	assign emit    = ~fifo_stat.empty & (~out_vld_q | pop);
	assign job_pop = emit & last;

	always_comb begin
		if (rs == upscl_pkg::ROW_ABOVE) begin
			p0 = job.up0;
			p1 = job.up1;
			p2 = job.up2;
		end else begin
			p0 = job.mid0;
			p1 = job.mid1;
			p2 = job.mid2;
		end
		case (cs)
			upscl_pkg::COL_LEFT_EVEN: px = p0;
			upscl_pkg::COL_LEFT_ODD:  px = p1;
			default:                  px = p2;
		endcase
		nxt.out_col   = {job.col, 1'b0} + upscl_pkg::OCOL_W'(cs) - upscl_pkg::OCOL_W'(2);
		nxt.out_row   = {job.row, 1'b0} + upscl_pkg::OROW_W'(rs) - upscl_pkg::OROW_W'(1);
		nxt.out_blue  = px[7:0];
		nxt.out_green = px[15:8];
		nxt.out_red   = px[23:16];
		nxt.run_last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q      <= upscl_pkg::ROW_ABOVE;
			cs_q      <= upscl_pkg::COL_LEFT_EVEN;
			started_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
				started_q <= ~last;
				if (cs == cs_end) begin
					cs_q <= cs_start;
					rs_q <= rs + 1'b1;
				end else begin
					cs_q <= cs + 1'b1;
					rs_q <= rs;
				end
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= nxt;
		end
	end

	assign empty  = ~out_vld_q;
	assign result = result_q;

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> !fifo_stat.empty)
		else $error("Job in progress left the queue before its last result.");

	a_step_on: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !last) |=> started_q)
		else $error("Sequencer lost its place within a job.");

	a_job_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last) |=> !started_q)
		else $error("Sequencer did not return to the start after a job.");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> (rs_q == upscl_pkg::ROW_EVEN || rs_q == upscl_pkg::ROW_BELOW
			|| rs_q == upscl_pkg::ROW_ABOVE))
		else $error("Sequencer row step out of range.");

endmodule
`default_nettype wire

// ===== hw/rtl/bilinear_2x_upscaler_core.sv =====
// Top level of the bilinear 2x upscaler: front end, job queue and output sequencer.
// A pixel's results pass through the front-end stage, the job queue and the output register.
// Throughput: one result per cycle while a job is queued and the output register is empty or
// popped; a pixel yields 0 to 12 results, 4 on average, so the output port sets the pixel rate.
// Reset clears all control state and sets frame_width to 640 and frame_height to 480.
// The line buffer is not cleared; no result uses what the first row of a frame reads from it.
`default_nettype none
module bilinear_2x_upscaler_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [upscl_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [upscl_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire logic                          push,
	output logic                               full,
	input  wire upscl_pkg::in_item_t           pixel,
	output logic                               empty,
	input  wire logic                          pop,
	output upscl_pkg::out_item_t               result
);

	logic                  job_push;
	logic                  job_pop;
	upscl_pkg::job_t       job_in;
	upscl_pkg::job_t       job_head;
	upscl_pkg::fifo_stat_t fifo_stat;

	upscl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.job_push  (job_push),
		.job       (job_in),
		.fifo_stat (fifo_stat)
	);

	upscl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (job_in),
		.pop    (job_pop),
		.head   (job_head),
		.stat   (fifo_stat)
	);

	upscl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_head),
		.fifo_stat (fifo_stat),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire
